// ===== rtl/sparse_band_map_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Sparse band map allocator assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_BAND_MAP_ALLOCATOR_MACROS_SVH
`define SPARSE_BAND_MAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SBMA_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBMA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sbma_pkg.sv =====
// ----------------------------------------------------------------------------
// sbma_pkg
// Widths, constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sbma_pkg;

   localparam int unsigned OFS_W      = 48;  // image and drive offsets
   localparam int unsigned POS_W      = 49;  // offset plus partition start
   localparam int unsigned SUM_W      = 50;  // access end position
   localparam int unsigned CNT_W      = 25;  // byte counts
   localparam int unsigned SHIFT_W    = 5;
   localparam int unsigned BSZ_W      = 31;  // band size, up to 2^30
   localparam int unsigned IN_W       = 30;  // offset within a band
   localparam int unsigned SLOT_W     = 11;
   localparam int unsigned REC_W      = 10;
   localparam int unsigned NODE_NUM_W = 32;
   localparam int unsigned BANDNO_W   = 12;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned STAT_W     = 2;

   localparam int unsigned DEF_MAX_BANDS = 4096;
   localparam int unsigned HEADER_SLOTS  = 'h3F0;
   localparam int unsigned INDEX_SLOTS   = 'h3F2;
   localparam int unsigned NODE_BYTES    = 'h1000;
   localparam int unsigned MAX_COUNT     = 'h1000000;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd19;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd30;
   localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd20;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_WPROT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PART_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_EN   = 2'd3;

   typedef struct packed {
      logic              clear_step;
      logic              load;
      logic              check;
      logic              lookup;
      logic              open_node;
      logic              alloc;
      logic              emit_single;
      logic              emit_chunk;
      logic [STAT_W-1:0] code;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic err_range;
      logic wr_block;
      logic size_zero;
      logic is_write;
      logic base_zero;
      logic slot_full;
      logic last;
   } dp_status_type;

endpackage

// ===== rtl/sparse_band_map_allocator.sv =====
// ----------------------------------------------------------------------------
// sparse_band_map_allocator
// Maps read/write accesses on a sparse disk image to image file chunks,
// allocating bands and index nodes on first write.
// ----------------------------------------------------------------------------
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -------------------------
//   request   req_operation/byte_offset/byte_count    start && !busy
//   result    rsp_status ... rsp_last_chunk           rsp_valid, one cycle
//   config    csr_index, csr_data                     csr_write, no wait
//
// Steps: an access that ends in a single word (range error, write
// protection, zero length) goes through check and dispatch back to idle. A
// split access goes through check and dispatch, then per band through lookup
// and decide for a read or a mapped write, plus alloc for a band allocation,
// with node before alloc when an index node is opened first; the band table
// is read in lookup. Each word shows on the rsp_ ports the cycle after it is formed.
// Reset: synchronous, active high. After reset the band table is swept to
// zero, one entry per cycle, across all MAX_BANDS entries with busy high; csr writes
// are taken during the sweep.
// Stalls: the receiver cannot stall; busy holds off new requests.
//
module sparse_band_map_allocator
   import sbma_pkg::*;
#(
   parameter int unsigned MAX_BANDS = DEF_MAX_BANDS
) (
   input  logic                   clock,
   input  logic                   reset,
   // request word
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_operation,
   input  logic [OFS_W-1:0]       req_byte_offset,
   input  logic [CNT_W-1:0]       req_byte_count,
   // configuration
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [OFS_W-1:0]       csr_data,
   // result word
   output logic                   rsp_valid,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [OFS_W-1:0]       rsp_file_offset,
   output logic [CNT_W-1:0]       rsp_chunk_bytes,
   output logic                   rsp_zero_fill,
   output logic                   rsp_band_allocated,
   output logic [BANDNO_W-1:0]    rsp_band_number,
   output logic                   rsp_node_opened,
   output logic [OFS_W-1:0]       rsp_record_node_offset,
   output logic [REC_W-1:0]       rsp_record_slot,
   output logic [NODE_NUM_W-1:0]  rsp_node_number,
   output logic                   rsp_last_chunk
);

   ctl_cmd_type   cmd;
   dp_status_type stat;

   // sequencer: owns busy and steps the datapath one command per cycle
   sbma_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath: csr registers, band table, allocation state, result word
   sbma_datapath #(
      .MAX_BANDS (MAX_BANDS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_operation          (req_operation),
      .req_byte_offset        (req_byte_offset),
      .req_byte_count         (req_byte_count),
      .cmd                    (cmd),
      .stat                   (stat),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_file_offset        (rsp_file_offset),
      .rsp_chunk_bytes        (rsp_chunk_bytes),
      .rsp_zero_fill          (rsp_zero_fill),
      .rsp_band_allocated     (rsp_band_allocated),
      .rsp_band_number        (rsp_band_number),
      .rsp_node_opened        (rsp_node_opened),
      .rsp_record_node_offset (rsp_record_node_offset),
      .rsp_record_slot        (rsp_record_slot),
      .rsp_node_number        (rsp_node_number),
      .rsp_last_chunk         (rsp_last_chunk)
   );

endmodule

// ===== rtl/sbma_datapath.sv =====
// ----------------------------------------------------------------------------
// sbma_datapath
// Registers, band table memory, range check, band split and allocation.
// ----------------------------------------------------------------------------
`include "sparse_band_map_allocator_macros.svh"

module sbma_datapath
   import sbma_pkg::*;
#(
   parameter int unsigned MAX_BANDS = DEF_MAX_BANDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [OFS_W-1:0]       csr_data,
   input  logic                   req_operation,
   input  logic [OFS_W-1:0]       req_byte_offset,
   input  logic [CNT_W-1:0]       req_byte_count,
   input  ctl_cmd_type            cmd,
   output dp_status_type          stat,
   output logic                   rsp_valid,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [OFS_W-1:0]       rsp_file_offset,
   output logic [CNT_W-1:0]       rsp_chunk_bytes,
   output logic                   rsp_zero_fill,
   output logic                   rsp_band_allocated,
   output logic [BANDNO_W-1:0]    rsp_band_number,
   output logic                   rsp_node_opened,
   output logic [OFS_W-1:0]       rsp_record_node_offset,
   output logic [REC_W-1:0]       rsp_record_slot,
   output logic [NODE_NUM_W-1:0]  rsp_node_number,
   output logic                   rsp_last_chunk
);

   localparam int unsigned IDX_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int unsigned BAND_W = (IDX_W > BANDNO_W) ? IDX_W : BANDNO_W;
   localparam int unsigned SLOT_CAP =
      (HEADER_SLOTS > INDEX_SLOTS) ? HEADER_SLOTS : INDEX_SLOTS;

   function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] v);
      if (v < SHIFT_MIN) return SHIFT_MIN;
      if (v > SHIFT_MAX) return SHIFT_MAX;
      return v;
   endfunction

   // configuration
   logic [OFS_W-1:0]       part_start_ff;
   logic [OFS_W-1:0]       drive_ff;
   logic [SHIFT_W-1:0]     shift_ff;
   logic                   wen_ff;

   // access in flight
   logic                   op_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       size_ff;
   logic                   err_range_ff;
   logic [BAND_W-1:0]      band_ff;
   logic [IN_W-1:0]        in_band_ff;
   logic [CNT_W-1:0]       len_ff;
   logic [OFS_W-1:0]       rd_ff;
   logic                   opened_ff;
   logic [NODE_NUM_W-1:0]  opened_num_ff;

   // allocation state
   logic [OFS_W-1:0]       image_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [OFS_W-1:0]       node_off_ff;
   logic [NODE_NUM_W-1:0]  node_num_ff;
   logic [IDX_W-1:0]       clr_cnt_ff;

   // result registers
   logic                   rsp_valid_ff;
   logic [STAT_W-1:0]      rsp_status_ff;
   logic [OFS_W-1:0]       rsp_file_offset_ff;
   logic [CNT_W-1:0]       rsp_chunk_bytes_ff;
   logic                   rsp_zero_fill_ff;
   logic                   rsp_band_alloc_ff;
   logic [BANDNO_W-1:0]    rsp_band_number_ff;
   logic                   rsp_node_opened_ff;
   logic [OFS_W-1:0]       rsp_record_node_ff;
   logic [REC_W-1:0]       rsp_record_slot_ff;
   logic [NODE_NUM_W-1:0]  rsp_node_number_ff;
   logic                   rsp_last_ff;

   logic [OFS_W-1:0]       band_table [MAX_BANDS];

   // combinational helpers
   logic [SUM_W-1:0]       end_sum;
   logic [SUM_W-1:0]       band_lim;
   logic                   err_range_in;
   logic [POS_W-1:0]       band_full;
   logic [BSZ_W-1:0]       band_bytes;
   logic [BSZ_W-1:0]       band_mask;
   logic [IN_W-1:0]        in_band_in;
   logic [BSZ_W-1:0]       room;
   logic [CNT_W-1:0]       len_in;
   logic [SLOT_W-1:0]      slot_limit;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [OFS_W-1:0]       mem_wd;
   logic                   zf_in;

   always_comb begin
      end_sum      = SUM_W'(pos_ff) + SUM_W'(size_ff);
      band_lim     = SUM_W'(MAX_BANDS) << shift_ff;
      err_range_in = (size_ff > CNT_W'(MAX_COUNT)) || (end_sum > SUM_W'(drive_ff)) ||
                     ((size_ff != '0) && (end_sum > band_lim));
      band_full    = pos_ff >> shift_ff;
      band_bytes   = BSZ_W'(1) << shift_ff;
      band_mask    = band_bytes - BSZ_W'(1);
      in_band_in   = pos_ff[IN_W-1:0] & band_mask[IN_W-1:0];
      room         = band_bytes - BSZ_W'(in_band_in);
      len_in       = (BSZ_W'(size_ff) > room) ? room[CNT_W-1:0] : size_ff;
      slot_limit   = (node_off_ff == '0) ? SLOT_W'(HEADER_SLOTS) : SLOT_W'(INDEX_SLOTS);
      mem_we       = cmd.clear_step | cmd.alloc;
      mem_wa       = cmd.clear_step ? clr_cnt_ff : band_ff[IDX_W-1:0];
      mem_wd       = cmd.clear_step ? '0 : image_ff;
      zf_in        = !op_ff && (rd_ff == '0);
   end

   assign stat.clear_last = (clr_cnt_ff == IDX_W'(MAX_BANDS - 1));
   assign stat.err_range  = err_range_ff;
   assign stat.wr_block   = op_ff && !wen_ff;
   assign stat.size_zero  = (size_ff == '0);
   assign stat.is_write   = op_ff;
   assign stat.base_zero  = (rd_ff == '0);
   assign stat.slot_full  = (slot_ff >= slot_limit);
   assign stat.last       = (size_ff == len_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         part_start_ff <= '0;
         drive_ff      <= '0;
         shift_ff      <= SHIFT_RST;
         wen_ff        <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PART_START: part_start_ff <= csr_data;
            CSR_DRIVE:      drive_ff      <= csr_data;
            CSR_SHIFT:      shift_ff      <= clamp_shift(csr_data[SHIFT_W-1:0]);
            CSR_WRITE_EN:   wen_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   // band table: one write port shared by clear sweep and allocation
   always_ff @(posedge clock) begin
      if (mem_we) begin
         band_table[mem_wa] <= mem_wd;
      end
      if (cmd.lookup) begin
         rd_ff <= band_table[band_full[IDX_W-1:0]];
      end
   end

   // access payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         pos_ff  <= POS_W'(req_byte_offset) + POS_W'(part_start_ff);
         size_ff <= req_byte_count;
      end else if (cmd.emit_chunk) begin
         pos_ff  <= pos_ff + POS_W'(len_ff);
         size_ff <= size_ff - len_ff;
      end
      if (cmd.check) begin
         err_range_ff <= err_range_in;
      end
      if (cmd.lookup) begin
         band_ff    <= band_full[BAND_W-1:0];
         in_band_ff <= in_band_in;
         len_ff     <= len_in;
      end
      if (cmd.open_node) begin
         opened_num_ff <= node_num_ff;
      end
   end

   // allocation state
   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff    <= OFS_W'(NODE_BYTES);
         slot_ff     <= '0;
         node_off_ff <= '0;
         node_num_ff <= '0;
         clr_cnt_ff  <= '0;
         opened_ff   <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
         if (cmd.lookup) begin
            opened_ff <= 1'b0;
         end
         if (cmd.open_node) begin
            node_off_ff <= image_ff;
            node_num_ff <= node_num_ff + NODE_NUM_W'(1);
            slot_ff     <= '0;
            image_ff    <= image_ff + OFS_W'(NODE_BYTES);
            opened_ff   <= 1'b1;
         end
         if (cmd.alloc) begin
            image_ff <= image_ff + OFS_W'(band_bytes);
            slot_ff  <= slot_ff + SLOT_W'(1);
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_single | cmd.emit_chunk;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_single) begin
         rsp_status_ff      <= cmd.code;
         rsp_file_offset_ff <= '0;
         rsp_chunk_bytes_ff <= '0;
         rsp_zero_fill_ff   <= 1'b0;
         rsp_band_alloc_ff  <= 1'b0;
         rsp_band_number_ff <= '0;
         rsp_node_opened_ff <= 1'b0;
         rsp_record_node_ff <= '0;
         rsp_record_slot_ff <= '0;
         rsp_node_number_ff <= '0;
         rsp_last_ff        <= 1'b1;
      end else if (cmd.emit_chunk) begin
         rsp_status_ff      <= STAT_OK;
         rsp_chunk_bytes_ff <= len_ff;
         rsp_last_ff        <= stat.last;
         if (cmd.alloc) begin
            rsp_file_offset_ff <= image_ff + OFS_W'(in_band_ff);
            rsp_zero_fill_ff   <= 1'b0;
            rsp_band_alloc_ff  <= 1'b1;
            rsp_band_number_ff <= band_ff[BANDNO_W-1:0];
            rsp_node_opened_ff <= opened_ff;
            rsp_record_node_ff <= node_off_ff;
            rsp_record_slot_ff <= slot_ff[REC_W-1:0];
            rsp_node_number_ff <= opened_ff ? opened_num_ff : '0;
         end else begin
            rsp_file_offset_ff <= zf_in ? '0 : rd_ff + OFS_W'(in_band_ff);
            rsp_zero_fill_ff   <= zf_in;
            rsp_band_alloc_ff  <= 1'b0;
            rsp_band_number_ff <= zf_in ? '0 : band_ff[BANDNO_W-1:0];
            rsp_node_opened_ff <= 1'b0;
            rsp_record_node_ff <= '0;
            rsp_record_slot_ff <= '0;
            rsp_node_number_ff <= '0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_file_offset        = rsp_file_offset_ff;
   assign rsp_chunk_bytes        = rsp_chunk_bytes_ff;
   assign rsp_zero_fill          = rsp_zero_fill_ff;
   assign rsp_band_allocated     = rsp_band_alloc_ff;
   assign rsp_band_number        = rsp_band_number_ff;
   assign rsp_node_opened        = rsp_node_opened_ff;
   assign rsp_record_node_offset = rsp_record_node_ff;
   assign rsp_record_slot        = rsp_record_slot_ff;
   assign rsp_node_number        = rsp_node_number_ff;
   assign rsp_last_chunk         = rsp_last_ff;

   `SBMA_ASSERT_NOW(a_zero_fill_clean, rsp_valid_ff && rsp_zero_fill_ff, !rsp_band_alloc_ff && (rsp_file_offset_ff == '0), "zero-fill word carries an offset or an allocation")
   `SBMA_ASSERT_NOW(a_node_first_slot, rsp_valid_ff && rsp_node_opened_ff, rsp_band_alloc_ff && (rsp_record_slot_ff == '0), "opened node not paired with an allocation in slot zero")
   `SBMA_ASSERT_NOW(a_error_is_last, rsp_valid_ff && (rsp_status_ff != STAT_OK), rsp_last_ff, "error word not marked last")
   `SBMA_ASSERT_NOW(a_slot_bound, 1'b1, slot_ff <= SLOT_W'(SLOT_CAP), "slot fill ran past the node size")

endmodule

// ===== rtl/sbma_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbma_ctrl
// Sequencer: table clear, range check, dispatch and per-band chunk steps.
// ----------------------------------------------------------------------------
`include "sparse_band_map_allocator_macros.svh"

module sbma_ctrl
   import sbma_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  dp_status_type  stat,
   output ctl_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DISPATCH,
      ST_LOOKUP,
      ST_DECIDE,
      ST_NODE,
      ST_ALLOC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (stat.err_range) begin
               cmd.emit_single = 1'b1;
               cmd.code        = STAT_RANGE;
               state_in        = ST_IDLE;
            end else if (stat.wr_block) begin
               cmd.emit_single = 1'b1;
               cmd.code        = STAT_WPROT;
               state_in        = ST_IDLE;
            end else if (stat.size_zero) begin
               cmd.emit_single = 1'b1;
               cmd.code        = STAT_OK;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.is_write && stat.base_zero) begin
               state_in = stat.slot_full ? ST_NODE : ST_ALLOC;
            end else begin
               cmd.emit_chunk = 1'b1;
               state_in       = stat.last ? ST_IDLE : ST_LOOKUP;
            end
         end
         ST_NODE: begin
            cmd.open_node = 1'b1;
            state_in      = ST_ALLOC;
         end
         ST_ALLOC: begin
            cmd.alloc      = 1'b1;
            cmd.emit_chunk = 1'b1;
            state_in       = stat.last ? ST_IDLE : ST_LOOKUP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   `SBMA_ASSERT_NEXT(a_accept_busy, start && !busy_ff, busy_ff && (state_ff == ST_CHECK), "accepted word did not enter the range check")

endmodule

// ===== test/sparse_band_map_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_band_map_allocator_test
// Self-checking bench for the sparse band map allocator. A directed burst hits
// the range, write-protect, zero-length, band-limit and shift-clamp cases; then
// randomized accesses under several register settings fill the band table far
// enough to open index nodes. Every result word is checked against a
// cycle-free model of the band table, image growth and index node slots.
// ----------------------------------------------------------------------------
module sparse_band_map_allocator_test
   import sbma_pkg::*;
();

   localparam bit OP_READ  = 1'b0;
   localparam bit OP_WRITE = 1'b1;

   typedef struct packed {
      logic [STAT_W-1:0]     status;
      logic [OFS_W-1:0]      file_offset;
      logic [CNT_W-1:0]      chunk_bytes;
      logic                  zero_fill;
      logic                  band_allocated;
      logic [BANDNO_W-1:0]   band_number;
      logic                  node_opened;
      logic [OFS_W-1:0]      record_node_offset;
      logic [REC_W-1:0]      record_slot;
      logic [NODE_NUM_W-1:0] node_number;
      logic                  last_chunk;
   } chunk_word_type;

   class band_map_tracker;
      // register copies
      bit [OFS_W-1:0]      part_start;
      bit [OFS_W-1:0]      drive_size;
      bit [SHIFT_W-1:0]    shift_reg;
      bit                  writes_allowed;
      // allocation state
      bit [OFS_W-1:0]      band_map [DEF_MAX_BANDS];
      bit [OFS_W-1:0]      image_bytes;
      bit [SLOT_W-1:0]     slot_fill;
      bit [OFS_W-1:0]      cur_node_ofs;
      bit [NODE_NUM_W-1:0] node_count;
      // words still owed by the block, oldest first
      chunk_word_type      chunks_due [$];
      int unsigned         accesses, words_seen, allocations, nodes_opened, mismatches;

      function new();
         part_start     = '0;
         drive_size     = '0;
         shift_reg      = SHIFT_RST;
         writes_allowed = 1'b0;
         foreach (band_map[i]) band_map[i] = '0;
         image_bytes    = OFS_W'(NODE_BYTES);
         slot_fill      = '0;
         cur_node_ofs   = '0;
         node_count     = '0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [OFS_W-1:0] data);
         case (idx)
            CSR_PART_START: part_start     = data;
            CSR_DRIVE:      drive_size     = data;
            CSR_SHIFT:      shift_reg      = data[SHIFT_W-1:0];
            CSR_WRITE_EN:   writes_allowed = data[0];
            default: ;
         endcase
      endfunction

      function int unsigned band_bits();
         if (shift_reg < SHIFT_MIN) return int'(SHIFT_MIN);
         if (shift_reg > SHIFT_MAX) return int'(SHIFT_MAX);
         return int'(shift_reg);
      endfunction

      function chunk_word_type lone_word(logic [STAT_W-1:0] code);
         chunk_word_type w;
         w = '0;
         w.status = code;
         w.last_chunk = 1'b1;
         return w;
      endfunction

      // Split one access into band chunks, allocating as a write demands.
      function void note_access(bit op, logic [OFS_W-1:0] off, logic [CNT_W-1:0] cnt);
         longint unsigned pos, remain, band, in_band, len, base, bsz, slots;
         int unsigned sh;
         chunk_word_type w;
         accesses++;
         sh = band_bits();
         bsz = 64'd1 << sh;
         pos = 64'(off) + 64'(part_start);
         remain = 64'(cnt);
         if (remain > MAX_COUNT || pos + remain > 64'(drive_size) ||
             (remain != 0 && ((pos + remain - 1) >> sh) >= DEF_MAX_BANDS)) begin
            chunks_due.push_back(lone_word(STAT_RANGE));
            return;
         end
         if (op == OP_WRITE && !writes_allowed) begin
            chunks_due.push_back(lone_word(STAT_WPROT));
            return;
         end
         if (remain == 0) begin
            chunks_due.push_back(lone_word(STAT_OK));
            return;
         end
         while (remain > 0) begin
            band = pos >> sh;
            in_band = pos & (bsz - 1);
            len = (in_band + remain > bsz) ? bsz - in_band : remain;
            base = 64'(band_map[band]);
            w = '0;
            w.status = STAT_OK;
            w.chunk_bytes = CNT_W'(len);
            w.band_number = BANDNO_W'(band);
            if (op == OP_READ) begin
               if (base == 0) begin
                  w.zero_fill = 1'b1;
                  w.band_number = '0;
               end else begin
                  w.file_offset = OFS_W'(base + in_band);
               end
            end else begin
               if (base == 0) begin
                  slots = (cur_node_ofs == 0) ? 64'(HEADER_SLOTS) : 64'(INDEX_SLOTS);
                  if (slot_fill >= slots) begin
                     cur_node_ofs = image_bytes;
                     w.node_opened = 1'b1;
                     w.node_number = node_count;
                     node_count++;
                     slot_fill = '0;
                     image_bytes = image_bytes + OFS_W'(NODE_BYTES);
                     nodes_opened++;
                  end
                  base = 64'(image_bytes);
                  image_bytes = image_bytes + OFS_W'(bsz);
                  w.band_allocated = 1'b1;
                  w.record_node_offset = cur_node_ofs;
                  w.record_slot = slot_fill[REC_W-1:0];
                  slot_fill++;
                  band_map[band] = OFS_W'(base);
                  allocations++;
               end
               w.file_offset = OFS_W'(base + in_band);
            end
            remain -= len;
            pos += len;
            if (remain == 0) w.last_chunk = 1'b1;
            chunks_due.push_back(w);
         end
      endfunction

      function void check_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_word(chunk_word_type got);
         chunk_word_type want;
         words_seen++;
         if (chunks_due.size() == 0) begin
            $error("result word with nothing pending (status %0d, band %0d)",
                   got.status, got.band_number);
            mismatches++;
            return;
         end
         want = chunks_due.pop_front();
         check_field("status", want.status, got.status);
         check_field("file_offset", want.file_offset, got.file_offset);
         check_field("chunk_bytes", want.chunk_bytes, got.chunk_bytes);
         check_field("zero_fill", want.zero_fill, got.zero_fill);
         check_field("band_allocated", want.band_allocated, got.band_allocated);
         check_field("band_number", want.band_number, got.band_number);
         check_field("node_opened", want.node_opened, got.node_opened);
         check_field("record_node_offset", want.record_node_offset,
                     got.record_node_offset);
         check_field("record_slot", want.record_slot, got.record_slot);
         check_field("node_number", want.node_number, got.node_number);
         check_field("last_chunk", want.last_chunk, got.last_chunk);
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned IDLE_PCT     = 30;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_operation = 1'b0;
   logic [OFS_W-1:0]      req_byte_offset = '0;
   logic [CNT_W-1:0]      req_byte_count = '0;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [OFS_W-1:0]      csr_data = '0;
   logic                  rsp_valid;
   logic [STAT_W-1:0]     rsp_status;
   logic [OFS_W-1:0]      rsp_file_offset;
   logic [CNT_W-1:0]      rsp_chunk_bytes;
   logic                  rsp_zero_fill;
   logic                  rsp_band_allocated;
   logic [BANDNO_W-1:0]   rsp_band_number;
   logic                  rsp_node_opened;
   logic [OFS_W-1:0]      rsp_record_node_offset;
   logic [REC_W-1:0]      rsp_record_slot;
   logic [NODE_NUM_W-1:0] rsp_node_number;
   logic                  rsp_last_chunk;

   chunk_word_type        rsp_word;
   band_map_tracker       tracker;
   int unsigned           cycle_count = 0;
   longint unsigned       access_cursor = 0;

   sparse_band_map_allocator uut (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gather the result ports into one word, in the struct's field order.
   assign rsp_word = {rsp_status, rsp_file_offset, rsp_chunk_bytes, rsp_zero_fill,
                      rsp_band_allocated, rsp_band_number, rsp_node_opened,
                      rsp_record_node_offset, rsp_record_slot, rsp_node_number,
                      rsp_last_chunk};

   // A result word lives for one cycle only: take it at the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_word(rsp_word);
   end

   // Watchdog: give up well past the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending",
                  cycle_count, tracker.chunks_due.size());
         $display("sparse_band_map_allocator_test: errors");
         $finish;
      end
   end

   // Present one access word and hold it until the block takes it. Called at
   // a rising edge; start stays high if the caller follows up right away.
   task automatic send_access(input bit op, input logic [OFS_W-1:0] off,
                              input logic [CNT_W-1:0] cnt);
      start           <= 1'b1;
      req_operation   <= op;
      req_byte_offset <= off;
      req_byte_count  <= cnt;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_access(op, off, cnt);
   endtask

   // Drop start and let the clock run with no request.
   task automatic idle_for(input int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drop start and wait until every owed word is in and the block is idle.
   task automatic settle();
      start <= 1'b0;
      while (tracker.chunks_due.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic put_register(input logic [CSR_IDX_W-1:0] idx, input logic [OFS_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   // Write all four registers back to back. Shift and write enable carry
   // random upper bits, which the block must ignore.
   task automatic configure(input logic [OFS_W-1:0] ps, input logic [OFS_W-1:0] db,
                            input logic [SHIFT_W-1:0] sh, input bit we);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      put_register(CSR_PART_START, ps);
      put_register(CSR_DRIVE, db);
      put_register(CSR_SHIFT, {junk[OFS_W-1:SHIFT_W], sh});
      put_register(CSR_WRITE_EN, {junk[OFS_W-1:1], we});
      csr_write <= 1'b0;
   endtask

   // One random access. Most land inside the drive so that bands get mapped;
   // a walking cursor strings accesses together so fresh bands keep coming.
   task automatic random_access(input int unsigned write_pct, input bit idle_on);
      longint unsigned room, cnt, off;
      int unsigned pick;
      bit op;
      pick = $urandom_range(99);
      op = ($urandom_range(99) < write_pct) ? OP_WRITE : OP_READ;
      room = (tracker.drive_size > tracker.part_start) ?
             64'(tracker.drive_size) - 64'(tracker.part_start) : 0;
      if (pick < 8 || room == 0) begin
         // noise: anything the ports can carry, mostly range errors
         off = {$urandom, $urandom} & ((64'd1 << OFS_W) - 1);
         cnt = $urandom_range((1 << CNT_W) - 1);
      end else begin
         if (pick < 14)      cnt = 0;
         else if (pick < 40) cnt = MAX_COUNT;
         else if (pick < 75) cnt = $urandom_range(MAX_COUNT, 1);
         else                cnt = $urandom_range(NODE_BYTES, 1);
         if (cnt > room) cnt = room;
         if (access_cursor + cnt > room) access_cursor = 0;
         if ($urandom_range(1) == 1) off = access_cursor;
         else off = {$urandom, $urandom} % (room - cnt + 1);
         access_cursor = off + cnt;
      end
      if (idle_on && $urandom_range(99) < IDLE_PCT) idle_for($urandom_range(19, 1));
      send_access(op, OFS_W'(off), CNT_W'(cnt));
   endtask

   task automatic run_phase(input int unsigned items, input int unsigned write_pct,
                            input bit idle_on);
      repeat (items) random_access(write_pct, idle_on);
      settle();
   endtask

   initial begin
      logic [OFS_W-1:0] ps;
      logic [SHIFT_W-1:0] sh;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed: huge drive, 1 MiB bands, writes locked
      // Registers are taken during the post-reset table sweep.
      configure('0, {OFS_W{1'b1}}, SHIFT_RST, 1'b0);
      send_access(OP_READ, '0, '0);                        // zero length
      send_access(OP_READ, '0, CNT_W'(NODE_BYTES));        // unmapped read
      send_access(OP_WRITE, '0, CNT_W'(NODE_BYTES));       // write locked
      send_access(OP_WRITE, '0, '0);                       // locked beats zero length
      send_access(OP_READ, '0, {CNT_W{1'b1}});             // count field maxed
      send_access(OP_READ, '0, CNT_W'(MAX_COUNT + 1));     // just over the count cap
      send_access(OP_READ, {OFS_W{1'b1}}, CNT_W'(1));      // past drive end
      send_access(OP_READ, OFS_W'(64'd4096 << 20), CNT_W'(1));       // band past table
      send_access(OP_READ, OFS_W'((64'd4096 << 20) - 1), CNT_W'(1)); // last band
      settle();

      // --- directed: shift below range clamps to 512 KiB bands, writes open
      configure(OFS_W'(NODE_BYTES), OFS_W'((64'd1 << 31) + NODE_BYTES), '0, 1'b1);
      send_access(OP_WRITE, OFS_W'((1 << 19) - 100), CNT_W'(200));   // lands in one band
      send_access(OP_WRITE, '0, CNT_W'(MAX_COUNT));                  // 33 chunks
      send_access(OP_WRITE, OFS_W'(1 << 18), CNT_W'(MAX_COUNT));     // all bands already mapped
      send_access(OP_READ, '0, CNT_W'(MAX_COUNT));                   // mapped reads
      send_access(OP_READ, OFS_W'((64'd1 << 31) - 1), CNT_W'(1));    // in drive, past table
      send_access(OP_READ, OFS_W'((64'd1 << 31) - NODE_BYTES - 1), CNT_W'(1));
      send_access(OP_WRITE, '0, '0);
      settle();

      // --- directed: everything maxed, shift above range clamps to 1 GiB
      configure({OFS_W{1'b1}}, {OFS_W{1'b1}}, {SHIFT_W{1'b1}}, 1'b1);
      send_access(OP_READ, '0, '0);                        // ends exactly at drive end
      send_access(OP_READ, '0, CNT_W'(1));
      send_access(OP_WRITE, {OFS_W{1'b1}}, CNT_W'(1));
      settle();

      // --- directed: 1 GiB bands across a boundary
      configure('0, OFS_W'(64'd1 << 32), SHIFT_MAX, 1'b1);
      send_access(OP_WRITE, OFS_W'((64'd1 << 30) - 8), CNT_W'(16));
      send_access(OP_READ, OFS_W'((64'd1 << 30) - 8), CNT_W'(16));
      send_access(OP_WRITE, '0, '0);
      settle();

      // --- directed: empty drive
      configure('0, '0, SHIFT_MIN, 1'b1);
      send_access(OP_READ, '0, CNT_W'(1));
      send_access(OP_READ, '0, '0);
      settle();

      // --- random: small bands, write heavy, to run the header out of slots
      configure('0, OFS_W'(64'd1 << 31), SHIFT_MIN, 1'b1);
      run_phase(50, 85, 1'b1);

      ps = OFS_W'($urandom_range(1 << 20));
      configure(ps, OFS_W'(64'(ps) + (64'd4096 << 20)), SHIFT_RST, 1'b1);
      run_phase(45, 60, 1'b1);

      // writes locked, random band size and offset
      sh = SHIFT_W'($urandom_range(SHIFT_MAX, SHIFT_MIN));
      ps = OFS_W'({$urandom_range(255), $urandom});
      configure(ps, OFS_W'(64'(ps) + (64'd4096 << sh)), sh, 1'b0);
      run_phase(40, 40, 1'b1);

      // drive reaches past the table, so the band limit trips as well
      configure('0, OFS_W'((64'd4096 << 19) + (1 << 20)), SHIFT_MIN, 1'b1);
      run_phase(50, 90, 1'b1);

      sh = SHIFT_W'($urandom_range(SHIFT_MAX, SHIFT_MIN));
      ps = OFS_W'({$urandom_range(255), $urandom});
      configure(ps, OFS_W'(64'(ps) + (64'd4096 << sh)), sh, 1'b1);
      run_phase(40, 50, 1'b1);

      // closing stretch: back to back, no gaps
      configure('0, OFS_W'(64'd1 << 31), SHIFT_MIN, 1'b1);
      run_phase(45, 70, 1'b0);

      // hold for any stray word
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d accesses, %0d result words checked", tracker.accesses,
               tracker.words_seen);
      $display("%0d bands allocated, %0d index nodes opened", tracker.allocations,
               tracker.nodes_opened);
      if (tracker.mismatches == 0 && tracker.chunks_due.size() == 0) begin
         $display("sparse_band_map_allocator_test: clean");
      end else begin
         $display("sparse_band_map_allocator_test: errors");
      end
      $finish;
   end

endmodule
